// ===== hw/rtl/ccta_pkg.sv =====
// Shared types and constants for the credit and cost table admission block.
// Holds the request and response transaction structs, command codes and status codes.
// Depends on nothing.
package ccta_pkg;

  localparam int KEY_W = 32;
  localparam int CREDIT_W = 64;
  localparam int COST_W = 32;

  localparam logic [CREDIT_W-1:0] ABSENT_CREDITS = 64'd2147483646;

  typedef enum logic [2:0] {
    CMD_GET_CREDITS    = 3'd0,
    CMD_UPDATE_CREDITS = 3'd1,
    CMD_REMOVE_APP     = 3'd2,
    CMD_UPDATE_COST    = 3'd3,
    CMD_GET_COST       = 3'd4,
    CMD_CHECK_ALLOWED  = 3'd5
  } cmd_t;

  localparam logic [1:0] ST_NOT_FOUND  = 2'd0;
  localparam logic [1:0] ST_FOUND      = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_RESERVED   = 2'd3;

  typedef struct packed {
    logic        [2:0]  command;
    logic signed [31:0] user_id;
    logic signed [31:0] operation_id;
    logic signed [63:0] amount;
  } req_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic        [1:0]  status;
    logic               allowed;
  } rsp_t;

  typedef struct packed {
    logic clearing;
    logic done;
    logic found;
    logic has_free;
  } scan_stat_t;

endpackage

// ===== hw/rtl/ccta_table.sv =====
// One key-value table in a synchronous memory with a sequential lookup scan.
// Reports the first matching entry and the first free entry; clears valid bits after reset.
// Depends on ccta_pkg.
module ccta_table #(
  parameter int ENTRIES = 16,
  parameter int VAL_W = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ccta_pkg::KEY_W-1:0]        key,
  input  logic                              wr_en,
  input  logic                              wr_valid,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_idx,
  input  logic [VAL_W-1:0]                  wr_val,
  output ccta_pkg::scan_stat_t              stat,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] hit_idx,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] free_idx,
  output logic [VAL_W-1:0]                  hit_val
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ENT_W = 1 + ccta_pkg::KEY_W + VAL_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  logic [ENT_W-1:0] mem [ENTRIES];
  logic [ENT_W-1:0] rdata;

  logic             clearing;
  logic [IDX_W-1:0] clr_idx;
  logic             issuing;
  logic [IDX_W-1:0] issue_idx;
  logic             chk_v;
  logic [IDX_W-1:0] chk_idx;
  logic             done;
  logic             found;
  logic             has_free;

  logic                       rd_valid;
  logic [ccta_pkg::KEY_W-1:0] rd_key;
  logic [VAL_W-1:0]           rd_val;

  assign rd_valid = rdata[ENT_W-1];
  assign rd_key   = rdata[ENT_W-2 -: ccta_pkg::KEY_W];
  assign rd_val   = rdata[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_idx] <= {wr_valid, key, wr_val};
    end
    rdata <= mem[issue_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      issuing   <= 1'b0;
      issue_idx <= '0;
      chk_v     <= 1'b0;
      chk_idx   <= '0;
      done      <= 1'b0;
      found     <= 1'b0;
      has_free  <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_idx == LAST) begin
          clearing <= 1'b0;
        end else begin
          clr_idx <= clr_idx + 1'b1;
        end
      end
      chk_v   <= issuing;
      chk_idx <= issue_idx;
      if (start) begin
        issuing   <= 1'b1;
        issue_idx <= '0;
        done      <= 1'b0;
        found     <= 1'b0;
        has_free  <= 1'b0;
      end else begin
        if (issuing) begin
          if (issue_idx == LAST) begin
            issuing <= 1'b0;
          end else begin
            issue_idx <= issue_idx + 1'b1;
          end
        end
        if (chk_v) begin
          if (rd_valid && rd_key == key && !found) begin
            found <= 1'b1;
          end
          if (!rd_valid && !has_free) begin
            has_free <= 1'b1;
          end
          if (chk_idx == LAST) begin
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chk_v && !start) begin
      if (rd_valid && rd_key == key && !found) begin
        hit_idx <= chk_idx;
        hit_val <= rd_val;
      end
      if (!rd_valid && !has_free) begin
        free_idx <= chk_idx;
      end
    end
  end

  assign stat.clearing = clearing;
  assign stat.done     = done;
  assign stat.found    = found;
  assign stat.has_free = has_free;

endmodule

// ===== hw/rtl/credit_and_cost_table_admission.sv =====
// Credit and cost table admission: account and cost tables with an admission check.
// The response follows a scan of the table memories that reads one entry per cycle;
// one request at a time, so a new request is taken only after the previous response
// has been issued.
// Reset: a clearing pass over every table entry with req_ready low.
// Depends on ccta_pkg and ccta_table.
module credit_and_cost_table_admission #(
  parameter int ACCOUNT_ENTRIES = 16,
  parameter int COST_ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ccta_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ccta_pkg::rsp_t rsp
);

  localparam int A_IDX_W = (ACCOUNT_ENTRIES > 1) ? $clog2(ACCOUNT_ENTRIES) : 1;
  localparam int C_IDX_W = (COST_ENTRIES > 1) ? $clog2(COST_ENTRIES) : 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t         state, state_next;
  ccta_pkg::req_t held;
  ccta_pkg::rsp_t rsp_next;

  logic accept;
  logic fire;

  ccta_pkg::scan_stat_t            a_stat, c_stat;
  logic [A_IDX_W-1:0]              a_hit_idx, a_free_idx, a_wr_idx;
  logic [C_IDX_W-1:0]              c_hit_idx, c_free_idx, c_wr_idx;
  logic [ccta_pkg::CREDIT_W-1:0]   a_hit_val;
  logic [ccta_pkg::COST_W-1:0]     c_hit_val;
  logic                            a_we, a_wvalid, c_we, c_wvalid;
  logic [ccta_pkg::CREDIT_W-1:0]   credits, cost;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign fire      = (state == S_DONE) && (!rsp_valid || rsp_ready);

  ccta_table #(
    .ENTRIES(ACCOUNT_ENTRIES),
    .VAL_W(ccta_pkg::CREDIT_W)
  ) u_account (
    .clk(clk),
    .rst(rst),
    .start(accept),
    .key(held.user_id),
    .wr_en(a_we),
    .wr_valid(a_wvalid),
    .wr_idx(a_wr_idx),
    .wr_val(held.amount),
    .stat(a_stat),
    .hit_idx(a_hit_idx),
    .free_idx(a_free_idx),
    .hit_val(a_hit_val)
  );

  ccta_table #(
    .ENTRIES(COST_ENTRIES),
    .VAL_W(ccta_pkg::COST_W)
  ) u_cost (
    .clk(clk),
    .rst(rst),
    .start(accept),
    .key(held.operation_id),
    .wr_en(c_we),
    .wr_valid(c_wvalid),
    .wr_idx(c_wr_idx),
    .wr_val(held.amount[ccta_pkg::COST_W-1:0]),
    .stat(c_stat),
    .hit_idx(c_hit_idx),
    .free_idx(c_free_idx),
    .hit_val(c_hit_val)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (!a_stat.clearing && !c_stat.clearing) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (a_stat.done && c_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign credits = a_stat.found ? a_hit_val : ccta_pkg::ABSENT_CREDITS;
  assign cost    = c_stat.found
                 ? {{(ccta_pkg::CREDIT_W - ccta_pkg::COST_W){c_hit_val[ccta_pkg::COST_W-1]}},
                    c_hit_val}
                 : '0;

  always_comb begin
    rsp_next = '0;
    a_we     = 1'b0;
    a_wvalid = 1'b1;
    a_wr_idx = a_stat.found ? a_hit_idx : a_free_idx;
    c_we     = 1'b0;
    c_wvalid = 1'b1;
    c_wr_idx = c_stat.found ? c_hit_idx : c_free_idx;
    case (held.command)
      ccta_pkg::CMD_GET_CREDITS: begin
        rsp_next.value  = credits;
        rsp_next.status = a_stat.found ? ccta_pkg::ST_FOUND : ccta_pkg::ST_NOT_FOUND;
      end
      ccta_pkg::CMD_UPDATE_CREDITS: begin
        if (a_stat.found) begin
          a_we            = fire;
          rsp_next.status = ccta_pkg::ST_FOUND;
        end else if (a_stat.has_free) begin
          a_we            = fire;
          rsp_next.status = ccta_pkg::ST_NOT_FOUND;
        end else begin
          rsp_next.status = ccta_pkg::ST_TABLE_FULL;
        end
      end
      ccta_pkg::CMD_REMOVE_APP: begin
        if (a_stat.found) begin
          a_we            = fire;
          a_wvalid        = 1'b0;
          rsp_next.status = ccta_pkg::ST_FOUND;
        end
      end
      ccta_pkg::CMD_UPDATE_COST: begin
        if (c_stat.found) begin
          c_we            = fire;
          rsp_next.status = ccta_pkg::ST_FOUND;
        end else if (c_stat.has_free) begin
          c_we            = fire;
          rsp_next.status = ccta_pkg::ST_NOT_FOUND;
        end else begin
          rsp_next.status = ccta_pkg::ST_TABLE_FULL;
        end
      end
      ccta_pkg::CMD_GET_COST: begin
        rsp_next.value  = cost;
        rsp_next.status = c_stat.found ? ccta_pkg::ST_FOUND : ccta_pkg::ST_NOT_FOUND;
      end
      ccta_pkg::CMD_CHECK_ALLOWED: begin
        rsp_next.allowed = ($signed(credits) >= $signed(cost));
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= req;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) accept |=> !req_ready)
    else $error("request accepted while a transaction was still in flight");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status != ccta_pkg::ST_RESERVED)
    else $error("response carries a reserved status code");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ccta_pkg::ST_TABLE_FULL |-> rsp.value == '0 && !rsp.allowed)
    else $error("table_full response carries a value or an allowed flag");

  assert property (@(posedge clk) disable iff (rst) $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("response raised outside the completion state");

  assert property (@(posedge clk) disable iff (rst) (a_we || c_we) |-> state == S_DONE && fire)
    else $error("table write outside a completing transaction");

endmodule

// ===== dv/credit_and_cost_table_admission_checker.sv =====
// Response checker for credit_and_cost_table_admission: mirrors both tables,
// predicts each response transaction and compares it field by field.
// Depends on ccta_pkg.
module credit_and_cost_table_admission_checker #(
  parameter int ACCOUNT_ENTRIES = 16,
  parameter int COST_ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  ccta_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  ccta_pkg::rsp_t rsp,
  output int             mismatches,
  output int             outstanding
);
  import ccta_pkg::*;

  logic [KEY_W-1:0]    acct_key    [ACCOUNT_ENTRIES];
  logic [CREDIT_W-1:0] acct_credit [ACCOUNT_ENTRIES];
  logic                acct_live   [ACCOUNT_ENTRIES];
  logic [KEY_W-1:0]    cost_key    [COST_ENTRIES];
  logic [COST_W-1:0]   cost_val    [COST_ENTRIES];
  logic                cost_live   [COST_ENTRIES];

  rsp_t predicted_responses[$];

  function automatic int match_slot(input bit in_cost_table, input logic [KEY_W-1:0] key);
    if (in_cost_table) begin
      for (int i = 0; i < COST_ENTRIES; i++)
        if (cost_live[i] && cost_key[i] == key) return i;
    end else begin
      for (int i = 0; i < ACCOUNT_ENTRIES; i++)
        if (acct_live[i] && acct_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic int free_slot(input bit in_cost_table);
    if (in_cost_table) begin
      for (int i = 0; i < COST_ENTRIES; i++)
        if (!cost_live[i]) return i;
    end else begin
      for (int i = 0; i < ACCOUNT_ENTRIES; i++)
        if (!acct_live[i]) return i;
    end
    return -1;
  endfunction

  // Apply one command to the mirrored tables and return its response.
  function automatic rsp_t apply_command(input req_t r);
    rsp_t                 o;
    int                   a_idx;
    int                   c_idx;
    int                   slot;
    logic signed [63:0]   credit;
    logic signed [63:0]   cost;
    o = '0;
    a_idx = match_slot(1'b0, r.user_id);
    c_idx = match_slot(1'b1, r.operation_id);
    credit = (a_idx >= 0) ? acct_credit[a_idx] : ABSENT_CREDITS;
    cost = (c_idx >= 0) ? {{32{cost_val[c_idx][COST_W-1]}}, cost_val[c_idx]} : 64'sd0;
    case (r.command)
      CMD_GET_CREDITS: begin
        o.value = credit;
        o.status = (a_idx >= 0) ? ST_FOUND : ST_NOT_FOUND;
      end
      CMD_UPDATE_CREDITS: begin
        if (a_idx >= 0) begin
          acct_credit[a_idx] = r.amount;
          o.status = ST_FOUND;
        end else begin
          slot = free_slot(1'b0);
          if (slot >= 0) begin
            acct_key[slot] = r.user_id;
            acct_credit[slot] = r.amount;
            acct_live[slot] = 1'b1;
            o.status = ST_NOT_FOUND;
          end else begin
            o.status = ST_TABLE_FULL;
          end
        end
      end
      CMD_REMOVE_APP: begin
        if (a_idx >= 0) begin
          acct_live[a_idx] = 1'b0;
          o.status = ST_FOUND;
        end
      end
      CMD_UPDATE_COST: begin
        if (c_idx >= 0) begin
          cost_val[c_idx] = r.amount[COST_W-1:0];
          o.status = ST_FOUND;
        end else begin
          slot = free_slot(1'b1);
          if (slot >= 0) begin
            cost_key[slot] = r.operation_id;
            cost_val[slot] = r.amount[COST_W-1:0];
            cost_live[slot] = 1'b1;
            o.status = ST_NOT_FOUND;
          end else begin
            o.status = ST_TABLE_FULL;
          end
        end
      end
      CMD_GET_COST: begin
        o.value = cost;
        o.status = (c_idx >= 0) ? ST_FOUND : ST_NOT_FOUND;
      end
      CMD_CHECK_ALLOWED: begin
        o.allowed = (credit >= cost);
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t on %s: got %h, expected %h", $time, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < ACCOUNT_ENTRIES; i++) acct_live[i] = 1'b0;
      for (int i = 0; i < COST_ENTRIES; i++) cost_live[i] = 1'b0;
      predicted_responses.delete();
      mismatches = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (predicted_responses.size() == 0) begin
          report_mismatch("response with no request waiting", rsp.value, '0);
        end else begin
          want = predicted_responses.pop_front();
          if (rsp.value !== want.value) report_mismatch("value", rsp.value, want.value);
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.allowed !== want.allowed)
            report_mismatch("allowed", 64'(rsp.allowed), 64'(want.allowed));
        end
      end
      if (req_valid && req_ready) predicted_responses.push_back(apply_command(req));
    end
    outstanding <= predicted_responses.size();
  end

endmodule

// ===== dv/credit_and_cost_table_admission_test.sv =====
// Testbench top for credit_and_cost_table_admission: drives directed and random
// request transactions, applies response backpressure and gives the verdict.
// Depends on ccta_pkg, the block and credit_and_cost_table_admission_checker.
module credit_and_cost_table_admission_test;
  import ccta_pkg::*;

  localparam int ACCOUNT_ENTRIES = 16;
  localparam int COST_ENTRIES = 16;
  localparam int LATENCY =
    ((ACCOUNT_ENTRIES > COST_ENTRIES) ? ACCOUNT_ENTRIES : COST_ENTRIES) + 3;
  localparam int SEGMENT_ITEMS = 175;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  int   mismatches;
  int   outstanding;
  bit   no_idle = 1'b0;

  credit_and_cost_table_admission #(
    .ACCOUNT_ENTRIES(ACCOUNT_ENTRIES),
    .COST_ENTRIES(COST_ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  credit_and_cost_table_admission_checker #(
    .ACCOUNT_ENTRIES(ACCOUNT_ENTRIES),
    .COST_ENTRIES(COST_ENTRIES)
  ) response_check (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    rsp_ready <= !rst && (no_idle || $urandom_range(99) >= 23);
  end

  task automatic send_request(input logic [2:0] cmd, input logic [31:0] uid,
                              input logic [31:0] oid, input logic [63:0] amt);
    req_t item;
    item.command = cmd;
    item.user_id = uid;
    item.operation_id = oid;
    item.amount = amt;
    while (!no_idle && $urandom_range(99) < 23) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key(input int pool);
    int idx;
    idx = $urandom_range(pool - 1);
    if ($urandom_range(15) == 0) return $urandom;
    case (idx)
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return idx * 32'h9e37_79b1;
    endcase
  endfunction

  initial begin
    int          pool;
    logic [2:0]  cmd;
    logic [63:0] amt;
    int          pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_request(CMD_GET_CREDITS, 32'h0, 32'h0, 64'h0);
    send_request(CMD_GET_COST, 32'h0, 32'h0, 64'h0);
    send_request(CMD_CHECK_ALLOWED, 32'h0, 32'h0, 64'h0);
    send_request(CMD_UPDATE_CREDITS, 32'h8000_0000, 32'h0, 64'h8000_0000_0000_0000);
    send_request(CMD_GET_CREDITS, 32'h8000_0000, 32'h0, 64'h0);
    send_request(CMD_CHECK_ALLOWED, 32'h8000_0000, 32'h0, 64'h0);
    send_request(CMD_UPDATE_CREDITS, 32'h8000_0000, 32'hffff_ffff, 64'h7fff_ffff_ffff_ffff);
    send_request(CMD_UPDATE_COST, 32'h0, 32'h7fff_ffff, 64'h1234_5678_8000_0000);
    send_request(CMD_GET_COST, 32'h0, 32'h7fff_ffff, 64'h0);
    send_request(CMD_UPDATE_COST, 32'h0, 32'h7fff_ffff, 64'hffff_ffff_7fff_ffff);
    send_request(CMD_CHECK_ALLOWED, 32'h8000_0000, 32'h7fff_ffff, 64'h0);
    send_request(CMD_UPDATE_CREDITS, 32'hffff_ffff, 32'h0, 64'd2147483647);
    send_request(CMD_UPDATE_COST, 32'h0, 32'hffff_ffff, 64'd2147483647);
    send_request(CMD_CHECK_ALLOWED, 32'hffff_ffff, 32'hffff_ffff, 64'h0);
    send_request(CMD_UPDATE_CREDITS, 32'hffff_ffff, 32'h0, 64'd2147483646);
    send_request(CMD_CHECK_ALLOWED, 32'hffff_ffff, 32'hffff_ffff, 64'h0);
    send_request(CMD_CHECK_ALLOWED, 32'h0000_0005, 32'hffff_ffff, 64'h0);
    send_request(CMD_REMOVE_APP, 32'hffff_ffff, 32'h0, 64'h0);
    send_request(CMD_REMOVE_APP, 32'hffff_ffff, 32'h0, 64'h0);
    send_request(CMD_GET_CREDITS, 32'hffff_ffff, 32'h0, 64'h0);
    send_request(CMD_SPARE_6, 32'hffff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_request(CMD_SPARE_7, 32'h8000_0000, 32'h7fff_ffff, 64'h8000_0000_0000_0001);
    send_request(CMD_REMOVE_APP, 32'h8000_0000, 32'h0, 64'h0);

    for (int seg = 0; seg < 4; seg++) begin
      pool = (seg == 1) ? 6 : ((seg == 3) ? 40 : 24);
      no_idle <= (seg == 2);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 15) cmd = CMD_GET_CREDITS;
        else if (pick < 40) cmd = CMD_UPDATE_CREDITS;
        else if (pick < 50) cmd = CMD_REMOVE_APP;
        else if (pick < 70) cmd = CMD_UPDATE_COST;
        else if (pick < 80) cmd = CMD_GET_COST;
        else if (pick < 97) cmd = CMD_CHECK_ALLOWED;
        else if (pick < 99) cmd = CMD_SPARE_6;
        else cmd = CMD_SPARE_7;
        case ($urandom_range(7))
          0: amt = 64'h8000_0000_0000_0000;
          1: amt = 64'h7fff_ffff_ffff_ffff;
          2: amt = 64'd2147483646 + $urandom_range(2) - 1;
          3, 4: amt = 64'($signed($urandom_range(20)) - 10);
          default: amt = {$urandom, $urandom};
        endcase
        send_request(cmd, pick_key(pool), pick_key(pool), amt);
      end
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
